FILE: hw/rtl/spd_pkg.sv
// Shared types and constants for the scan packet deframer.
// No dependencies; imported by every other module of the block.
`default_nettype none

package spd_pkg;

    typedef logic [7:0] byte_t;
    typedef logic [3:0] pos_t;

    // Frame position of the footer byte, the last one of a frame.
    localparam pos_t FRAME_LAST = 4'd13;
    // Last position that enters the checksum.
    localparam pos_t XOR_LAST = 4'd11;
    // Bytes 1 to 12 are held in the chain of cells.
    localparam int CHAIN_LEN = 12;

    localparam byte_t HEADER_RESET = 8'hAA;
    localparam byte_t FOOTER_RESET = 8'h55;

    // Register indexes of the configuration port.
    localparam logic [7:0] REG_HEADER = 8'd0;
    localparam logic [7:0] REG_FOOTER = 8'd1;

    // Control from the framing sequencer to the data path.
    typedef struct packed {
        logic  shift;    // accepted byte belongs to positions 1 to 12
        logic  last;     // accepted byte is the footer position
        byte_t xor_sum;  // running checksum over bytes 1 to 11
    } ctrl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/spd_cell.sv
// One byte cell of the frame chain: takes its neighbor's byte on shift.
// Depends on spd_pkg for the byte type.
`default_nettype none

module spd_cell (
    input  wire logic          clk,
    input  wire logic          shift,
    input  wire spd_pkg::byte_t data_in,
    output spd_pkg::byte_t     data_out
);
    import spd_pkg::*;

    byte_t byte_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            byte_reg <= data_in;
        end
    end

    assign data_out = byte_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/spd_ctrl.sv
// Framing sequencer: header hunt, frame position counter and running XOR.
// Depends on spd_pkg for types and frame constants.
`default_nettype none

module spd_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           fire,
    input  wire spd_pkg::byte_t rx_byte,
    input  wire spd_pkg::byte_t header_byte,
    output spd_pkg::ctrl_t      ctrl
);
    import spd_pkg::*;

    pos_t  pos_reg;
    pos_t  pos_next;
    byte_t xor_reg;
    byte_t xor_next;
    logic  in_frame;

    // Positions 1 to 12 shift into the chain; 13 closes the frame.
    assign in_frame = (pos_reg != 4'd0) && (pos_reg < FRAME_LAST);

    always_comb
    begin
        pos_next = pos_reg;
        xor_next = xor_reg;
        if (fire)
        begin
            if (pos_reg == 4'd0)
            begin
                if (rx_byte == header_byte)
                begin
                    pos_next = 4'd1;
                    xor_next = 8'd0;
                end
            end
            else if (in_frame)
            begin
                pos_next = pos_reg + 4'd1;
                if (pos_reg <= XOR_LAST)
                begin
                    xor_next = xor_reg ^ rx_byte;
                end
            end
            else
            begin
                // Footer position, or a position that cannot arise.
                pos_next = 4'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= 4'd0;
            xor_reg <= 8'd0;
        end
        else
        begin
            pos_reg <= pos_next;
            xor_reg <= xor_next;
        end
    end

    assign ctrl.shift   = fire && in_frame;
    assign ctrl.last    = fire && (pos_reg == FRAME_LAST);
    assign ctrl.xor_sum = xor_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/scan_packet_deframer.sv
// Top level of the scan packet deframer.
// Depends on spd_pkg, spd_ctrl and spd_cell.
//
// The block takes one received byte per item on the input channel
// (in_valid, in_stall, rx_byte) and hunts for the header byte. The 13 bytes
// after a header form the rest of a fixed 14-byte frame; a header value
// inside a frame is plain data. Bytes 1 to 12 move down a chain of twelve
// byte cells, one cell per cycle in which a frame byte is accepted, while a
// sequencer counts the position and keeps the XOR of bytes 1 to 11.
// When the footer position arrives, the checksum (byte 12, at the head of
// the chain) and the footer are checked, and a good frame loads one result
// item (distance_mm, angle_tenths, timestamp_ms) into the output register.
// Bad frames are dropped without notice.
//
// Throughput is one byte per cycle while in_stall is low. A result appears
// on out_valid in the cycle after its footer byte is accepted. The output
// register parts the two channels: input is stalled only while a result is
// held and the receiver stalls it, so bytes keep flowing between frames.
// The configuration port (cfg_valid, cfg_ready, cfg_index, cfg_data) is
// always ready; index 0 is the header byte, 1 the footer byte, and other
// indexes are ignored. Reset returns the block to hunting, empties the
// output register and loads the header and footer defaults.
`default_nettype none

module scan_packet_deframer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  rx_byte,
    // Output channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [15:0]      distance_mm,
    output logic signed [15:0] angle_tenths,
    output logic [31:0]      timestamp_ms,
    // Configuration write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);
    import spd_pkg::*;

    byte_t header_reg;
    byte_t footer_reg;
    logic  fire;
    ctrl_t ctrl;
    byte_t chain [CHAIN_LEN];
    logic  frame_good;
    logic  out_valid_reg;
    logic  out_valid_next;
    logic [15:0]        dist_reg;
    logic signed [15:0] angle_reg;
    logic [31:0]        time_reg;

    // Configuration registers; writes are taken in every cycle.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg <= HEADER_RESET;
            footer_reg <= FOOTER_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_HEADER)
            begin
                header_reg <= cfg_data;
            end
            else if (cfg_index == REG_FOOTER)
            begin
                footer_reg <= cfg_data;
            end
        end
    end

    // A byte can only be refused while a result waits on a stalled receiver.
    assign in_stall = out_valid_reg && out_stall;
    assign fire     = in_valid && !in_stall;

    spd_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .rx_byte     (rx_byte),
        .header_byte (header_reg),
        .ctrl        (ctrl)
    );

    // Cell 0 takes the newest byte; after byte 12 frame byte k sits in
    // cell 12 - k.
    for (genvar i = 0; i < CHAIN_LEN; i++)
    begin : g_chain
        if (i == 0)
        begin : g_head
            spd_cell u_cell (
                .clk      (clk),
                .shift    (ctrl.shift),
                .data_in  (rx_byte),
                .data_out (chain[i])
            );
        end
        else
        begin : g_body
            spd_cell u_cell (
                .clk      (clk),
                .shift    (ctrl.shift),
                .data_in  (chain[i-1]),
                .data_out (chain[i])
            );
        end
    end

    // Checksum byte is at the head of the chain when the footer arrives.
    assign frame_good = ctrl.last && (chain[0] == ctrl.xor_sum)
                        && (rx_byte == footer_reg);

    assign out_valid_next = frame_good || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Little-endian fields: distance bytes 2-3, angle 4-5, time 6-9.
    always_ff @(posedge clk)
    begin
        if (frame_good)
        begin
            dist_reg  <= {chain[9], chain[10]};
            angle_reg <= $signed({chain[7], chain[8]});
            time_reg  <= {chain[3], chain[4], chain[5], chain[6]};
        end
    end

    assign out_valid    = out_valid_reg;
    assign distance_mm  = dist_reg;
    assign angle_tenths = angle_reg;
    assign timestamp_ms = time_reg;

    // A new result is always preceded by an accepted footer byte.
    a_result_has_byte: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall))
        else $error("result appeared without an accepted byte");

    // Frames are 14 bytes long, so a taken result is never followed at once.
    a_results_spaced: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall) |=> !out_valid)
        else $error("two results in consecutive cycles");

    // A held result keeps its distance and timestamp fields while the receiver stalls.
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(distance_mm)
                                      && $stable(timestamp_ms)))
        else $error("stalled result changed");

endmodule

`default_nettype wire
